// ----- src/drt_pkg.sv -----
package drt_pkg;

    localparam int COORD_W = 11;
    localparam int EXT_W   = 12;
    localparam int VOL_W   = 3 * EXT_W;
    localparam int AREA_W  = 2 * EXT_W;
    localparam int SPAN_W  = EXT_W + 1;

    localparam logic [EXT_W-1:0] EXT_MAX   = {EXT_W{1'b1}};
    localparam logic [EXT_W-1:0] VOL_RESET = 12'd2048;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_ADD   = 2'd0;
    localparam t_mode MODE_FULL  = 2'd1;
    localparam t_mode MODE_CLEAR = 2'd2;

    typedef logic [1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_VOL_WIDTH  = 2'd0;
    localparam t_cfg_addr CFG_VOL_HEIGHT = 2'd1;
    localparam t_cfg_addr CFG_VOL_DEPTH  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [EXT_W-1:0]   w;
        logic [EXT_W-1:0]   h;
        logic [EXT_W-1:0]   d;
    } t_box;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COVER,
        S_MA1,
        S_MA2,
        S_MB1,
        S_MB2,
        S_COMMIT
    } t_state;

endpackage

// ----- src/drt_cover.sv -----
module drt_cover (
    input  drt_pkg::t_box i_a,
    input  drt_pkg::t_box i_b,
    output drt_pkg::t_box o_cover
);
    import drt_pkg::*;

    // one axis of the bounding cover, extent saturated to the field width
    function automatic logic [COORD_W+EXT_W-1:0] axis_cover(
        input logic [COORD_W-1:0] pa,
        input logic [EXT_W-1:0]   ea,
        input logic [COORD_W-1:0] pb,
        input logic [EXT_W-1:0]   eb
    );
        logic [COORD_W-1:0] lo;
        logic [SPAN_W-1:0]  end_a;
        logic [SPAN_W-1:0]  end_b;
        logic [SPAN_W-1:0]  hi;
        logic [SPAN_W-1:0]  span;
        logic [EXT_W-1:0]   ext;
        lo    = (pa < pb) ? pa : pb;
        end_a = {2'b00, pa} + {1'b0, ea};
        end_b = {2'b00, pb} + {1'b0, eb};
        hi    = (end_a > end_b) ? end_a : end_b;
        span  = hi - {2'b00, lo};
        ext   = span[SPAN_W-1] ? EXT_MAX : span[EXT_W-1:0];
        return {lo, ext};
    endfunction

    logic [COORD_W+EXT_W-1:0] ax_x;
    logic [COORD_W+EXT_W-1:0] ax_y;
    logic [COORD_W+EXT_W-1:0] ax_z;

    assign ax_x = axis_cover(i_a.x, i_a.w, i_b.x, i_b.w);
    assign ax_y = axis_cover(i_a.y, i_a.h, i_b.y, i_b.h);
    assign ax_z = axis_cover(i_a.z, i_a.d, i_b.z, i_b.d);

    assign o_cover.x = ax_x[COORD_W+EXT_W-1:EXT_W];
    assign o_cover.w = ax_x[EXT_W-1:0];
    assign o_cover.y = ax_y[COORD_W+EXT_W-1:EXT_W];
    assign o_cover.h = ax_y[EXT_W-1:0];
    assign o_cover.z = ax_z[COORD_W+EXT_W-1:EXT_W];
    assign o_cover.d = ax_z[EXT_W-1:0];

endmodule

// ----- src/drt_mul.sv -----
module drt_mul (
    input  logic [drt_pkg::AREA_W-1:0] i_a,
    input  logic [drt_pkg::EXT_W-1:0]  i_b,
    output logic [drt_pkg::VOL_W-1:0]  o_prod
);
    import drt_pkg::*;

    assign o_prod = VOL_W'(i_a) * VOL_W'(i_b);

endmodule

// ----- src/two_box_dirty_region_tracker.sv -----
// Two-box dirty region tracker.
// Input channel (i_valid / o_ready) carries one beat per command: add a box,
// mark the whole volume dirty, or clear both boxes (i_mode). Every beat
// produces one output beat (o_valid / i_ready) with both boxes after it.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into the volume size
// register at i_cfg_addr; write only while no command is in flight.
// Timing: the block takes one command at a time. A mark, clear, or an add
// into a clean first slot passes the cover step and then commits; an add
// against a set first box passes one cover step and four passes through
// the shared 24x12 multiplier (two per box volume) before it commits. A
// new command is taken the cycle after the result is loaded.
// The output register holds a finished result while the receiver stalls;
// the next command may be accepted meanwhile but commits only once the
// output register is free.
// Reset clears both boxes, empties the output register and sets the volume
// size registers to 2048.
module two_box_dirty_region_tracker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [1:0]                i_cfg_addr,
    input  logic [drt_pkg::EXT_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_mode,
    input  logic [drt_pkg::COORD_W-1:0] i_box_x,
    input  logic [drt_pkg::COORD_W-1:0] i_box_y,
    input  logic [drt_pkg::COORD_W-1:0] i_box_z,
    input  logic [drt_pkg::EXT_W-1:0] i_box_w,
    input  logic [drt_pkg::EXT_W-1:0] i_box_h,
    input  logic [drt_pkg::EXT_W-1:0] i_box_d,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [drt_pkg::COORD_W-1:0] o_first_x,
    output logic [drt_pkg::COORD_W-1:0] o_first_y,
    output logic [drt_pkg::COORD_W-1:0] o_first_z,
    output logic [drt_pkg::EXT_W-1:0] o_first_w,
    output logic [drt_pkg::EXT_W-1:0] o_first_h,
    output logic [drt_pkg::EXT_W-1:0] o_first_d,
    output logic [drt_pkg::COORD_W-1:0] o_second_x,
    output logic [drt_pkg::COORD_W-1:0] o_second_y,
    output logic [drt_pkg::COORD_W-1:0] o_second_z,
    output logic [drt_pkg::EXT_W-1:0] o_second_w,
    output logic [drt_pkg::EXT_W-1:0] o_second_h,
    output logic [drt_pkg::EXT_W-1:0] o_second_d
);
    import drt_pkg::*;

    t_state           r_state, n_state;
    t_mode            r_in_mode;
    t_box             r_in_box;
    t_box             r_first, n_first;
    t_box             r_second, n_second;
    t_box             r_ca, r_cb;
    t_box             cover_a, cover_b;
    t_box             vb_src;
    logic [AREA_W-1:0] r_tmp;
    logic [VOL_W-1:0] r_va, r_vb;
    logic [EXT_W-1:0] r_vol_w, r_vol_h, r_vol_d;
    logic             r_ovalid;
    t_box             r_out_first, r_out_second;
    logic [AREA_W-1:0] mul_a;
    logic [EXT_W-1:0] mul_b;
    logic [VOL_W-1:0] mul_p;
    logic [VOL_W+1:0] va2, vb3;
    logic             out_free;
    logic             commit;
    logic             accept;

    drt_cover u_cover_a (.i_a(r_first),  .i_b(r_in_box), .o_cover(cover_a));
    drt_cover u_cover_b (.i_a(r_second), .i_b(r_in_box), .o_cover(cover_b));
    drt_mul   u_mul     (.i_a(mul_a), .i_b(mul_b), .o_prod(mul_p));

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign commit   = (r_state == S_COMMIT) && out_free;

    // second volume: first box alone when the second slot is unused
    assign vb_src = (r_second.w == '0) ? r_first : r_cb;

    always_comb begin
        n_state = r_state;
        mul_a   = {{(AREA_W-EXT_W){1'b0}}, r_ca.w};
        mul_b   = r_ca.h;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_COVER;
            end
            S_COVER: begin
                if (r_in_mode == MODE_ADD && r_first.w != '0) n_state = S_MA1;
                else n_state = S_COMMIT;
            end
            S_MA1: begin
                n_state = S_MA2;
            end
            S_MA2: begin
                mul_a   = r_tmp;
                mul_b   = r_ca.d;
                n_state = S_MB1;
            end
            S_MB1: begin
                mul_a   = {{(AREA_W-EXT_W){1'b0}}, vb_src.w};
                mul_b   = vb_src.h;
                n_state = S_MB2;
            end
            S_MB2: begin
                mul_a   = r_tmp;
                mul_b   = vb_src.d;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign va2 = {1'b0, r_va, 1'b0};
    assign vb3 = {2'b00, r_vb} + {1'b0, r_vb, 1'b0};

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        unique case (r_in_mode)
            MODE_ADD: begin
                if (r_first.w == '0) begin
                    n_first = r_in_box;
                end else if (r_second.w == '0) begin
                    if (va2 > vb3) n_second = r_in_box;
                    else n_first = r_ca;
                end else if (r_va > r_vb) begin
                    n_second = r_cb;
                end else begin
                    n_first = r_ca;
                end
            end
            MODE_FULL: begin
                n_first   = '0;
                n_first.w = r_vol_w;
                n_first.h = r_vol_h;
                n_first.d = r_vol_d;
                n_second  = '0;
            end
            MODE_CLEAR: begin
                n_first  = '0;
                n_second = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (commit) begin
                r_first  <= n_first;
                r_second <= n_second;
            end
            if (commit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_w <= VOL_RESET;
            r_vol_h <= VOL_RESET;
            r_vol_d <= VOL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_VOL_WIDTH:  r_vol_w <= i_cfg_wdata;
                CFG_VOL_HEIGHT: r_vol_h <= i_cfg_wdata;
                CFG_VOL_DEPTH:  r_vol_d <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_mode  <= i_mode;
            r_in_box.x <= i_box_x;
            r_in_box.y <= i_box_y;
            r_in_box.z <= i_box_z;
            r_in_box.w <= i_box_w;
            r_in_box.h <= i_box_h;
            r_in_box.d <= i_box_d;
        end
        if (r_state == S_COVER) begin
            r_ca <= cover_a;
            r_cb <= cover_b;
        end
        if (r_state == S_MA1 || r_state == S_MB1) r_tmp <= mul_p[AREA_W-1:0];
        if (r_state == S_MA2) r_va <= mul_p;
        if (r_state == S_MB2) r_vb <= mul_p;
        if (commit) begin
            r_out_first  <= n_first;
            r_out_second <= n_second;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_first_x  = r_out_first.x;
    assign o_first_y  = r_out_first.y;
    assign o_first_z  = r_out_first.z;
    assign o_first_w  = r_out_first.w;
    assign o_first_h  = r_out_first.h;
    assign o_first_d  = r_out_first.d;
    assign o_second_x = r_out_second.x;
    assign o_second_y = r_out_second.y;
    assign o_second_z = r_out_second.z;
    assign o_second_w = r_out_second.w;
    assign o_second_h = r_out_second.h;
    assign o_second_d = r_out_second.d;

`ifndef ASSERT_OFF
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second.w != '0) |-> (r_first.w != '0))
        else $error("second box set while first box clean");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_COVER))
        else $error("accepted beat did not start evaluation");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (o_valid && o_first_w == r_first.w && o_second_w == r_second.w))
        else $error("output beat does not match committed boxes");
`endif

endmodule
